// File: hw/rtl/contiguous_bitmap_allocator_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous bitmap allocator
// Shared concurrent assertion forms, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_BITMAP_ALLOCATOR_TOP_DEFINES_SVH
`define CONTIGUOUS_BITMAP_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define CBA_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cba_pkg.sv
// ---------------------------------------------------------------------------
// Contiguous bitmap allocator package
// Field widths, bitmap word geometry, status and op codes, scan result type.
// ---------------------------------------------------------------------------
package cba_pkg;

   localparam int CBA_WORD_W  = 8;
   localparam int CBA_BIT_W   = 3;
   localparam int CBA_START_W = 8;
   localparam int CBA_LEN_W   = 9;
   localparam int CBA_GRANT_W = 8;

   localparam logic CBA_OP_ACQUIRE = 1'b0;
   localparam logic CBA_OP_RELEASE = 1'b1;

   typedef enum logic [1:0] {
      CBA_ST_OK        = 2'd0,
      CBA_ST_BAD_COUNT = 2'd1,
      CBA_ST_NO_SPACE  = 2'd2,
      CBA_ST_RANGE_ERR = 2'd3
   } cba_status_type;

   typedef struct packed {
      logic                 hit;
      logic [CBA_BIT_W-1:0] pos;
   } cba_hit_type;

endpackage

// File: hw/rtl/cba_bitmap_ram.sv
// ---------------------------------------------------------------------------
// Bitmap word RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module cba_bitmap_ram #(
   parameter int DEPTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [cba_pkg::CBA_WORD_W-1:0] wr_data,
   input  logic                           rd_en,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [cba_pkg::CBA_WORD_W-1:0] rd_data
);
   import cba_pkg::*;

   logic [CBA_WORD_W-1:0] mem [DEPTH];
   logic [CBA_WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cba_word_scan.sv
// ---------------------------------------------------------------------------
// Bitmap word scanner
// Extends the running free count across one word and finds the lowest bit
// at which the requested run length is reached.
// ---------------------------------------------------------------------------
module cba_word_scan #(
   parameter int CNT_W = 10
) (
   input  logic [cba_pkg::CBA_WORD_W-1:0] word_used,
   input  logic [CNT_W-1:0]               run_in,
   input  logic [CNT_W-1:0]               len,
   input  logic [CNT_W-1:0]               base,
   output cba_pkg::cba_hit_type           hit,
   output logic [CNT_W-1:0]               run_out,
   output logic [CNT_W-1:0]               found
);
   import cba_pkg::*;

   always_comb begin
      logic [CBA_BIT_W:0] local_run;
      logic               all_free;
      logic [CNT_W-1:0]   total;
      hit       = '0;
      local_run = '0;
      all_free  = 1'b1;
      for (int j = 0; j < CBA_WORD_W; j++) begin
         if (word_used[j]) begin
            local_run = '0;
            all_free  = 1'b0;
         end else begin
            local_run = local_run + 1'b1;
         end
         total = all_free ? run_in + CNT_W'(j + 1) : CNT_W'(local_run);
         if (!hit.hit && (total >= len)) begin
            hit.hit = 1'b1;
            hit.pos = CBA_BIT_W'(j);
         end
      end
      run_out = all_free ? run_in + CNT_W'(CBA_WORD_W) : CNT_W'(local_run);
      found   = base + CNT_W'(hit.pos) + CNT_W'(1) - len;
   end

endmodule

// File: hw/rtl/contiguous_bitmap_allocator_top.sv
// ---------------------------------------------------------------------------
// Contiguous bitmap allocator
// First-fit allocator over a used/free bitmap held in a word RAM.
//
//   channel  dir  beat contents
//   req_*    in   tuser: op; tdata: start_slot, run_length
//   rsp_*    out  tdata: status, granted_slot
//
// One request at a time; the sequencer handles each 8-slot word in a read
// state, then a check or write-back state. Acquire scans words from the
// first until the run fits, then marks it word by word; release clears the
// words it touches. Rejected requests go straight to the response state.
// After reset a clearing pass writes zeros over ceil(SLOT_COUNT/8) words,
// one per cycle, with req_tready low.
// The next request is taken while a response beat waits on rsp_tready.
// ---------------------------------------------------------------------------
`include "contiguous_bitmap_allocator_top_defines.svh"

module contiguous_bitmap_allocator_top #(
   parameter int SLOT_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] start_slot, [16:8] run_length, rest zero
   input  logic [0:0]  req_tuser,   // [0] op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [1:0] status, [9:2] granted_slot, rest zero
);
   import cba_pkg::*;

   localparam int WORDS  = (SLOT_COUNT + CBA_WORD_W - 1) / CBA_WORD_W;
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int SLOT_W = $clog2(SLOT_COUNT + 1);
   localparam int CNT_W  = ((SLOT_W > CBA_LEN_W) ? SLOT_W : CBA_LEN_W) + 1;

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_SRD   = 7'b0000100,
      S_SCHK  = 7'b0001000,
      S_MRD   = 7'b0010000,
      S_MWR   = 7'b0100000,
      S_RESP  = 7'b1000000
   } state_type;

   state_type                state_ff, state_in;
   logic [ADDR_W-1:0]        word_ff, word_in;
   logic [ADDR_W-1:0]        last_word_ff, last_word_in;
   logic [CNT_W-1:0]         run_ff, run_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic [CNT_W-1:0]         start_ff, start_in;
   logic [CNT_W-1:0]         end_ff, end_in;
   logic                     set_val_ff, set_val_in;
   cba_status_type           res_status_ff, res_status_in;
   logic [CBA_GRANT_W-1:0]   res_slot_ff, res_slot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   cba_status_type           rsp_status_ff, rsp_status_in;
   logic [CBA_GRANT_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                     req_fire;
   logic                     req_op;
   logic [CNT_W-1:0]         req_start;
   logic [CNT_W-1:0]         req_len;
   logic [CNT_W-1:0]         req_end;
   logic [CNT_W-1:0]         base;
   logic [CBA_WORD_W-1:0]    rd_data;
   logic [CBA_WORD_W-1:0]    scan_word;
   logic [CBA_WORD_W-1:0]    wr_data;
   logic                     wr_en;
   logic                     rd_en;
   cba_hit_type              scan_hit;
   logic [CNT_W-1:0]         scan_run;
   logic [CNT_W-1:0]         scan_found;
   logic [CNT_W-1:0]         found_end;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = req_tuser[0];
   assign req_start  = CNT_W'(req_tdata[CBA_START_W-1:0]);
   assign req_len    = CNT_W'(req_tdata[CBA_START_W +: CBA_LEN_W]);
   assign req_end    = req_start + req_len;
   assign base       = CNT_W'({word_ff, {CBA_BIT_W{1'b0}}});
   assign found_end  = scan_found + len_ff;

   // slots past capacity read as used
   always_comb begin
      for (int j = 0; j < CBA_WORD_W; j++) begin
         scan_word[j] = rd_data[j] || ((base + CNT_W'(j)) >= CNT_W'(SLOT_COUNT));
      end
   end

   // run mask merge for read-modify-write
   always_comb begin
      logic [CNT_W-1:0] idx;
      for (int j = 0; j < CBA_WORD_W; j++) begin
         idx        = base + CNT_W'(j);
         wr_data[j] = ((idx >= start_ff) && (idx < end_ff)) ? set_val_ff : rd_data[j];
      end
      if (state_ff == S_CLEAR) begin
         wr_data = '0;
      end
   end

   assign wr_en = (state_ff == S_CLEAR) || (state_ff == S_MWR);
   assign rd_en = (state_ff == S_SRD) || (state_ff == S_MRD);

   cba_bitmap_ram #(
      .DEPTH  (WORDS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (word_ff),
      .rd_data (rd_data)
   );

   cba_word_scan #(
      .CNT_W (CNT_W)
   ) u_scan (
      .word_used (scan_word),
      .run_in    (run_ff),
      .len       (len_ff),
      .base      (base),
      .hit       (scan_hit),
      .run_out   (scan_run),
      .found     (scan_found)
   );

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      last_word_in  = last_word_ff;
      run_in        = run_ff;
      len_in        = len_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      set_val_in    = set_val_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;

      unique case (state_ff)
         S_CLEAR: begin
            if (word_ff == ADDR_W'(WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               res_slot_in = '0;
               len_in      = req_len;
               if (req_op == CBA_OP_ACQUIRE) begin
                  if ((req_len == '0) || (req_len > CNT_W'(SLOT_COUNT))) begin
                     res_status_in = CBA_ST_BAD_COUNT;
                     state_in      = S_RESP;
                  end else begin
                     word_in    = '0;
                     run_in     = '0;
                     set_val_in = 1'b1;
                     state_in   = S_SRD;
                  end
               end else begin
                  if (req_end > CNT_W'(SLOT_COUNT)) begin
                     res_status_in = CBA_ST_RANGE_ERR;
                     state_in      = S_RESP;
                  end else if (req_len == '0) begin
                     res_status_in = CBA_ST_OK;
                     state_in      = S_RESP;
                  end else begin
                     res_status_in = CBA_ST_OK;
                     start_in      = req_start;
                     end_in        = req_end;
                     word_in       = ADDR_W'(req_start >> CBA_BIT_W);
                     last_word_in  = ADDR_W'((req_end - CNT_W'(1)) >> CBA_BIT_W);
                     set_val_in    = 1'b0;
                     state_in      = S_MRD;
                  end
               end
            end
         end
         S_SRD: begin
            state_in = S_SCHK;
         end
         S_SCHK: begin
            if (scan_hit.hit) begin
               res_status_in = CBA_ST_OK;
               res_slot_in   = scan_found[CBA_GRANT_W-1:0];
               start_in      = scan_found;
               end_in        = found_end;
               word_in       = ADDR_W'(scan_found >> CBA_BIT_W);
               last_word_in  = ADDR_W'((found_end - CNT_W'(1)) >> CBA_BIT_W);
               state_in      = S_MRD;
            end else if (word_ff == ADDR_W'(WORDS - 1)) begin
               res_status_in = CBA_ST_NO_SPACE;
               state_in      = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               run_in   = scan_run;
               state_in = S_SRD;
            end
         end
         S_MRD: begin
            state_in = S_MWR;
         end
         S_MWR: begin
            if (word_ff == last_word_ff) begin
               state_in = S_RESP;
            end else begin
               word_in  = word_ff + 1'b1;
               state_in = S_MRD;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_word_ff  <= last_word_in;
      run_ff        <= run_in;
      len_ff        <= len_in;
      start_ff      <= start_in;
      end_ff        <= end_in;
      set_val_ff    <= set_val_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = 16'({rsp_slot_ff, rsp_status_ff});

   `CBA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready,
      "request accepted while previous one still in progress")
   `CBA_ASSERT_IMPLIES(a_mark_in_range, clock, reset, state_ff == S_MWR,
      end_ff <= CNT_W'(SLOT_COUNT), "marked run extends past capacity")
   `CBA_ASSERT_IMPLIES(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff == S_RESP), "response loaded outside response state")
   `CBA_ASSERT_IMPLIES(a_scan_word_bound, clock, reset, state_ff == S_SCHK,
      word_ff <= ADDR_W'(WORDS - 1), "scan word beyond bitmap")

endmodule

// File: tb/sv/contiguous_bitmap_allocator_top_tb.sv
// ---------------------------------------------------------------------------
// Contiguous bitmap allocator testbench
// A directed table covers rejected counts, full and empty maps, range errors
// and first-fit placement. Mixed acquire/release traffic follows with
// bursty requests and a stalling response side. Every response beat is checked
// against the table's expected result or a first-fit model of the slot map.
// ---------------------------------------------------------------------------
module contiguous_bitmap_allocator_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cba_pkg::*;

   localparam int SLOTS           = 256;
   localparam int RANDOM_ITEMS    = 1525;
   localparam int DRAIN_CYCLES    = 160;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AFTER  = 300;
   localparam int LIMIT_NS        = 4_000_000;

   typedef struct packed {
      cba_status_type         status;
      logic [CBA_GRANT_W-1:0] slot;
   } slot_outcome_type;

   typedef struct packed {
      logic                   op;
      logic [CBA_START_W-1:0] start;
      logic [CBA_LEN_W-1:0]   len;
      logic                   typed;
      slot_outcome_type       result;
   } dir_row_type;

   typedef struct packed {
      logic [CBA_START_W-1:0] start;
      logic [CBA_LEN_W-1:0]   len;
   } run_type;

   typedef enum int {PACE_FULL, PACE_COIN, PACE_MOSTLY, PACE_PERIODIC} pace_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata  = '0;
   logic [0:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   logic [SLOTS-1:0] slot_busy;
   slot_outcome_type outcome_q[$];
   run_type          live_runs[$];
   int unsigned      fail_count    = 0;
   int unsigned      rsp_beats     = 0;
   int unsigned      acquire_count = 0;
   int unsigned      release_count = 0;
   int unsigned      burst_left    = 0;
   int unsigned      status_tally[4];
   bit               long_hold_done = 1'b0;

   contiguous_bitmap_allocator_top #(
      .SLOT_COUNT(SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // first-fit model; updates slot_busy
   function automatic slot_outcome_type apply_slot_request(logic op,
                                                        logic [CBA_START_W-1:0] start,
                                                        logic [CBA_LEN_W-1:0] len);
      slot_outcome_type res;
      int               run_len;
      int               base;
      bit               hit;
      res.status = CBA_ST_OK;
      res.slot   = '0;
      run_len    = 0;
      base       = 0;
      hit        = 1'b0;
      if (op == CBA_OP_ACQUIRE) begin
         if (len == 0 || int'(len) > SLOTS) begin
            res.status = CBA_ST_BAD_COUNT;
         end else begin
            for (int i = 0; i < SLOTS && !hit; i++) begin
               if (slot_busy[i]) begin
                  run_len = 0;
               end else begin
                  run_len++;
                  if (run_len == int'(len)) begin
                     base = i + 1 - int'(len);
                     hit  = 1'b1;
                  end
               end
            end
            if (!hit) begin
               res.status = CBA_ST_NO_SPACE;
            end else begin
               for (int i = 0; i < int'(len); i++) slot_busy[base + i] = 1'b1;
               res.slot = base[CBA_GRANT_W-1:0];
            end
         end
      end else if (int'(start) + int'(len) > SLOTS) begin
         res.status = CBA_ST_RANGE_ERR;
      end else begin
         for (int i = 0; i < int'(len); i++) slot_busy[int'(start) + i] = 1'b0;
      end
      return res;
   endfunction

   task automatic send_request(input logic op, input logic [CBA_START_W-1:0] start,
                               input logic [CBA_LEN_W-1:0] len, input logic typed,
                               input slot_outcome_type typed_result);
      slot_outcome_type predicted;
      int unsigned      gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 24);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'd0, len, start};
      do @(posedge clock); while (!req_tready);
      predicted = apply_slot_request(op, start, len);
      outcome_q.push_back(typed ? typed_result : predicted);
      status_tally[predicted.status]++;
      if (op == CBA_OP_ACQUIRE) begin
         acquire_count++;
         if (predicted.status == CBA_ST_OK) live_runs.push_back('{predicted.slot, len});
      end else begin
         release_count++;
      end
   endtask

   initial begin : rsp_pacing
      pace_type    mode;
      int unsigned span;
      int unsigned period;
      forever begin
         mode   = pace_type'($urandom_range(0, 3));
         span   = $urandom_range(20, 300);
         period = $urandom_range(2, 8);
         for (int c = 0; c < span; c++) begin
            if (!long_hold_done && rsp_beats >= HOLD_OFF_AFTER) begin
               for (int h = 0; h < HOLD_OFF_CYCLES; h++) begin
                  rsp_tready <= 1'b0;
                  @(posedge clock);
               end
               long_hold_done = 1'b1;
            end
            case (mode)
               PACE_FULL:   rsp_tready <= 1'b1;
               PACE_COIN:   rsp_tready <= ($urandom_range(0, 1) == 1);
               PACE_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:     rsp_tready <= (c % period == 0);
            endcase
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      slot_outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
         if (outcome_q.size() == 0) begin
            $error("response beat with no request pending: tdata 0x%h", rsp_tdata);
            fail_count++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[1:0]);
               fail_count++;
            end
            if (rsp_tdata[9:2] !== want.slot) begin
               $error("granted_slot: expected %0d, got %0d", want.slot, rsp_tdata[9:2]);
               fail_count++;
            end
         end
      end
   end

   initial begin : stimulus
      dir_row_type            dir_rows[$];
      run_type                victim;
      slot_outcome_type       none;
      int unsigned            pick;
      int unsigned            idx;
      logic [CBA_LEN_W-1:0]   len;
      logic [CBA_START_W-1:0] start;
      none      = '{CBA_ST_OK, 8'd0};
      slot_busy = '0;
      dir_rows  = '{
         '{CBA_OP_ACQUIRE, 8'd0,   9'd0,   1'b1, '{CBA_ST_BAD_COUNT, 8'd0}},
         '{CBA_OP_ACQUIRE, 8'd255, 9'd257, 1'b1, '{CBA_ST_BAD_COUNT, 8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd511, 1'b1, '{CBA_ST_BAD_COUNT, 8'd0}},
         '{CBA_OP_ACQUIRE, 8'h5A,  9'd1,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'hA5,  9'd3,   1'b1, '{CBA_ST_OK,        8'd1}},
         '{CBA_OP_RELEASE, 8'd255, 9'd2,   1'b1, '{CBA_ST_RANGE_ERR, 8'd0}},
         '{CBA_OP_RELEASE, 8'd255, 9'd511, 1'b1, '{CBA_ST_RANGE_ERR, 8'd0}},
         '{CBA_OP_RELEASE, 8'd0,   9'd257, 1'b1, '{CBA_ST_RANGE_ERR, 8'd0}},
         '{CBA_OP_RELEASE, 8'd0,   9'd0,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd0,   9'd1,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd1,   1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd256, 1'b1, '{CBA_ST_NO_SPACE,  8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd2,   1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd2,   9'd2,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd3,   1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd2,   1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd0,   9'd256, 1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd256, 1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd1,   1'b1, '{CBA_ST_NO_SPACE,  8'd0}},
         '{CBA_OP_RELEASE, 8'd255, 9'd1,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd1,   1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd128, 9'd128, 1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd130, 9'd5,   1'b1, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_ACQUIRE, 8'd0,   9'd128, 1'b0, '{CBA_ST_OK,        8'd0}},
         '{CBA_OP_RELEASE, 8'd0,   9'd256, 1'b1, '{CBA_ST_OK,        8'd0}}
      };
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[r]) begin
         send_request(dir_rows[r].op, dir_rows[r].start, dir_rows[r].len,
                      dir_rows[r].typed, dir_rows[r].result);
      end
      live_runs.delete();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
            // acquire, mostly short runs
            idx = $urandom_range(0, 99);
            if (idx < 70)      len = 9'($urandom_range(1, 16));
            else if (idx < 88) len = 9'($urandom_range(17, 64));
            else if (idx < 95) len = 9'($urandom_range(65, SLOTS));
            else if (idx < 97) len = 9'd0;
            else               len = 9'($urandom_range(SLOTS + 1, 511));
            send_request(CBA_OP_ACQUIRE, 8'($urandom), len, 1'b0, none);
         end else if (pick < 80) begin
            // give back a run that was granted earlier
            idx    = $urandom_range(0, live_runs.size() - 1);
            victim = live_runs[idx];
            live_runs.delete(idx);
            send_request(CBA_OP_RELEASE, victim.start, victim.len, 1'b0, none);
         end else if (pick < 82) begin
            live_runs.delete();
            send_request(CBA_OP_RELEASE, 8'd0, 9'(SLOTS), 1'b0, none);
         end else if (pick < 92) begin
            // stray or partial release, may run past the end
            start = 8'($urandom);
            len   = 9'($urandom_range(0, 40));
            send_request(CBA_OP_RELEASE, start, len, 1'b0, none);
         end else begin
            send_request(1'($urandom_range(0, 1)), 8'($urandom), 9'($urandom_range(0, 511)),
                         1'b0, none);
         end
      end
      req_tvalid <= 1'b0;

      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d acquires, %0d releases: %0d ok, %0d bad, %0d full, %0d range.",
               acquire_count, release_count, status_tally[CBA_ST_OK],
               status_tally[CBA_ST_BAD_COUNT], status_tally[CBA_ST_NO_SPACE],
               status_tally[CBA_ST_RANGE_ERR]);
      $display("Response side held off for %0d cycles under load: %s.", HOLD_OFF_CYCLES,
               long_hold_done ? "yes" : "no");
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("timeout with %0d responses outstanding", outcome_q.size());
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cba_pkg.sv
hw/rtl/cba_bitmap_ram.sv
hw/rtl/cba_word_scan.sv
hw/rtl/contiguous_bitmap_allocator_top.sv
tb/sv/contiguous_bitmap_allocator_top_tb.sv
